// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the response deframer
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge out of reset
`define BMS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define BMS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/bms_rdf_pkg.sv =====
// ----------------------------------------------------------------------------
// bms_rdf_pkg
// types and constants of the battery monitor response deframer
// ----------------------------------------------------------------------------
`default_nettype none

package bms_rdf_pkg;

  localparam int unsigned MaxFrameBytes = 64;
  localparam int unsigned FrameOverhead = 7;
  localparam int unsigned IdxW          = 6;

  localparam logic [7:0] START_BYTE = 8'hDD;
  localparam logic [7:0] END_BYTE   = 8'h77;

  localparam logic CMD_GAP = 1'b1;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  localparam logic [2:0] V_OK        = 3'd0;
  localparam logic [2:0] V_BAD_END   = 3'd1;
  localparam logic [2:0] V_CHECKSUM  = 3'd2;
  localparam logic [2:0] V_TRUNCATED = 3'd3;
  localparam logic [2:0] V_TOO_LONG  = 3'd4;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_ECHO    = 3'd1,
    PH_STATUS  = 3'd2,
    PH_LEN     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CHK_HI  = 3'd5,
    PH_CHK_LO  = 3'd6,
    PH_END     = 3'd7
  } phase_e;

  typedef struct packed {
    logic       command;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic            kind;
    logic [7:0]      payload_byte;
    logic [IdxW-1:0] payload_index;
    logic [2:0]      verdict;
    logic [7:0]      echo_code;
    logic [7:0]      status_code;
    logic [7:0]      payload_length;
  } out_item_t;

endpackage

`default_nettype wire

// ===== hdl/bms_response_deframer_core.sv =====
// ----------------------------------------------------------------------------
// bms_response_deframer_core
// battery monitor response frame deframer
// ----------------------------------------------------------------------------
// Takes one transfer per cycle: a received byte or a reception gap. Each
// transfer lands in an input register, passes through the frame parser and
// its result, if any, is written to a two-entry output queue, so a transfer
// is registered in the input register and its result then in the queue before
// the result is offered. The parser state machine handles one byte per cycle;
// the input side stalls only while the output queue is full.
`default_nettype none

module bms_response_deframer_core (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_ready_o,
  input  bms_rdf_pkg::in_item_t  in_item_i,
  output logic                   out_valid_o,
  input  wire                    out_ready_i,
  output bms_rdf_pkg::out_item_t out_item_o
);

  logic                   in_valid_q, in_valid_d;
  bms_rdf_pkg::in_item_t  in_item_q;
  logic                   has_space;
  logic                   step;
  logic                   res_valid;
  bms_rdf_pkg::out_item_t res;

  assign step       = in_valid_q && has_space;
  assign in_ready_o = !in_valid_q || has_space;
  assign in_valid_d = in_ready_o ? in_valid_i : in_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_item_q <= in_item_i;
    end
  end

  bms_rdf_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .item_i     (in_item_q),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  bms_rdf_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res_valid),
    .item_i     (res),
    .has_space_o(has_space),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

endmodule

`default_nettype wire

// ===== hdl/bms_rdf_parser.sv =====
// ----------------------------------------------------------------------------
// bms_rdf_parser
// frame state machine, running sum and result formation for one byte
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module bms_rdf_parser (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   step_i,
  input  bms_rdf_pkg::in_item_t item_i,
  output logic                  res_valid_o,
  output bms_rdf_pkg::out_item_t res_o
);

  bms_rdf_pkg::phase_e phase_q, phase_d;
  logic [15:0] sum_q, sum_d;
  logic [7:0]  idx_q, idx_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  echo_q, echo_d;
  logic [7:0]  status_q, status_d;
  logic [7:0]  chk_hi_q, chk_hi_d;
  logic        chk_bad_q, chk_bad_d;

  logic        gap;
  logic [7:0]  b;
  logic [15:0] sum_add;
  logic [8:0]  frame_len;
  logic        too_long;
  logic [7:0]  idx_inc;
  logic [15:0] want;

  assign gap       = (item_i.command == bms_rdf_pkg::CMD_GAP);
  assign b         = item_i.rx_byte;
  assign sum_add   = sum_q + {8'd0, b};
  assign frame_len = {1'b0, b} + 9'(bms_rdf_pkg::FrameOverhead);
  assign too_long  = (frame_len > 9'(bms_rdf_pkg::MaxFrameBytes));
  assign idx_inc   = idx_q + 8'd1;
  assign want      = 16'd0 - sum_q;

  // next state
  always_comb begin
    phase_d   = phase_q;
    sum_d     = sum_q;
    idx_d     = idx_q;
    len_d     = len_q;
    echo_d    = echo_q;
    status_d  = status_q;
    chk_hi_d  = chk_hi_q;
    chk_bad_d = chk_bad_q;
    if (step_i) begin
      if (gap) begin
        phase_d = bms_rdf_pkg::PH_HUNT;
      end else begin
        unique case (phase_q)
          bms_rdf_pkg::PH_HUNT: begin
            if (b == bms_rdf_pkg::START_BYTE) begin
              sum_d     = '0;
              idx_d     = '0;
              len_d     = '0;
              echo_d    = '0;
              status_d  = '0;
              chk_hi_d  = '0;
              chk_bad_d = 1'b0;
              phase_d   = bms_rdf_pkg::PH_ECHO;
            end
          end
          bms_rdf_pkg::PH_ECHO: begin
            echo_d  = b;
            phase_d = bms_rdf_pkg::PH_STATUS;
          end
          bms_rdf_pkg::PH_STATUS: begin
            status_d = b;
            sum_d    = sum_add;
            phase_d  = bms_rdf_pkg::PH_LEN;
          end
          bms_rdf_pkg::PH_LEN: begin
            len_d = b;
            sum_d = sum_add;
            idx_d = '0;
            if (too_long) begin
              phase_d = bms_rdf_pkg::PH_HUNT;
            end else if (b == 8'd0) begin
              phase_d = bms_rdf_pkg::PH_CHK_HI;
            end else begin
              phase_d = bms_rdf_pkg::PH_PAYLOAD;
            end
          end
          bms_rdf_pkg::PH_PAYLOAD: begin
            sum_d = sum_add;
            idx_d = idx_inc;
            if (idx_inc >= len_q) begin
              phase_d = bms_rdf_pkg::PH_CHK_HI;
            end
          end
          bms_rdf_pkg::PH_CHK_HI: begin
            chk_hi_d = b;
            phase_d  = bms_rdf_pkg::PH_CHK_LO;
          end
          bms_rdf_pkg::PH_CHK_LO: begin
            chk_bad_d = ({chk_hi_q, b} != want);
            phase_d   = bms_rdf_pkg::PH_END;
          end
          bms_rdf_pkg::PH_END: begin
            phase_d = bms_rdf_pkg::PH_HUNT;
          end
          default: begin
            phase_d = bms_rdf_pkg::PH_HUNT;
          end
        endcase
      end
    end
  end

  // result
  always_comb begin
    res_valid_o          = 1'b0;
    res_o.kind           = bms_rdf_pkg::KIND_VERDICT;
    res_o.payload_byte   = '0;
    res_o.payload_index  = '0;
    res_o.verdict        = bms_rdf_pkg::V_OK;
    res_o.echo_code      = echo_q;
    res_o.status_code    = status_q;
    res_o.payload_length = len_q;
    if (step_i) begin
      if (gap) begin
        res_valid_o   = (phase_q != bms_rdf_pkg::PH_HUNT);
        res_o.verdict = bms_rdf_pkg::V_TRUNCATED;
      end else begin
        unique case (phase_q)
          bms_rdf_pkg::PH_LEN: begin
            res_valid_o          = too_long;
            res_o.verdict        = bms_rdf_pkg::V_TOO_LONG;
            res_o.payload_length = b;
          end
          bms_rdf_pkg::PH_PAYLOAD: begin
            res_valid_o         = 1'b1;
            res_o.kind          = bms_rdf_pkg::KIND_PAYLOAD;
            res_o.payload_byte  = b;
            res_o.payload_index = idx_q[bms_rdf_pkg::IdxW-1:0];
          end
          bms_rdf_pkg::PH_END: begin
            res_valid_o = 1'b1;
            if (b != bms_rdf_pkg::END_BYTE) begin
              res_o.verdict = bms_rdf_pkg::V_BAD_END;
            end else if (chk_bad_q) begin
              res_o.verdict = bms_rdf_pkg::V_CHECKSUM;
            end else begin
              res_o.verdict = bms_rdf_pkg::V_OK;
            end
          end
          default: begin
            res_valid_o = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= bms_rdf_pkg::PH_HUNT;
      sum_q     <= '0;
      idx_q     <= '0;
      len_q     <= '0;
      echo_q    <= '0;
      status_q  <= '0;
      chk_hi_q  <= '0;
      chk_bad_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      sum_q     <= sum_d;
      idx_q     <= idx_d;
      len_q     <= len_d;
      echo_q    <= echo_d;
      status_q  <= status_d;
      chk_hi_q  <= chk_hi_d;
      chk_bad_q <= chk_bad_d;
    end
  end

  `BMS_ASSERT_IMPL(a_payload_in_range, clk_i, rst_ni,
    phase_q == bms_rdf_pkg::PH_PAYLOAD, idx_q < len_q)
  `BMS_ASSERT_IMPL(a_payload_only_in_payload, clk_i, rst_ni,
    res_valid_o && (res_o.kind == bms_rdf_pkg::KIND_PAYLOAD),
    phase_q == bms_rdf_pkg::PH_PAYLOAD)
  `BMS_ASSERT_IMPL(a_gap_while_hunting_silent, clk_i, rst_ni,
    step_i && gap && (phase_q == bms_rdf_pkg::PH_HUNT), !res_valid_o)
  `BMS_ASSERT(a_length_fits, clk_i, rst_ni,
    (phase_q == bms_rdf_pkg::PH_HUNT) || (phase_q == bms_rdf_pkg::PH_ECHO) ||
    (phase_q == bms_rdf_pkg::PH_STATUS) || (phase_q == bms_rdf_pkg::PH_LEN) ||
    ({1'b0, len_q} + 9'(bms_rdf_pkg::FrameOverhead) <=
     9'(bms_rdf_pkg::MaxFrameBytes)))

endmodule

`default_nettype wire

// ===== hdl/bms_rdf_out_buf.sv =====
// ----------------------------------------------------------------------------
// bms_rdf_out_buf
// two-entry result queue between the parser and the output channel
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module bms_rdf_out_buf (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    push_i,
  input  bms_rdf_pkg::out_item_t item_i,
  output logic                   has_space_o,
  output logic                   out_valid_o,
  input  wire                    out_ready_i,
  output bms_rdf_pkg::out_item_t out_item_o
);

  bms_rdf_pkg::out_item_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       pop;

  assign has_space_o = (count_q != 2'd2);
  assign out_valid_o = (count_q != 2'd0);
  assign out_item_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  `BMS_ASSERT_IMPL(a_no_push_when_full, clk_i, rst_ni, push_i, has_space_o)
  `BMS_ASSERT(a_count_matches_ptrs, clk_i, rst_ni,
    (count_q == 2'd1) == (wr_ptr_q != rd_ptr_q))

endmodule

`default_nettype wire

// ===== test/bms_response_deframer_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bms_response_deframer_core_test
// self-checking bench for the battery monitor response deframer: framed byte
// streams (good, bad end, bad checksum, cut by a gap, oversize, noise) go in
// under random idling on both sides, and every payload byte and verdict that
// comes out is checked against a frame parser model kept in a scoreboard
// ----------------------------------------------------------------------------

module bms_response_deframer_core_test;

  localparam logic CMD_BYTE = ~bms_rdf_pkg::CMD_GAP;
  localparam int unsigned ItemTarget = 1700;
  localparam int unsigned HoldCycles = 300;

  typedef enum int {
    FR_GOOD,
    FR_BAD_END,
    FR_BAD_SUM,
    FR_CUT,
    FR_OVERSIZE
  } flaw_e;

  class frame_scoreboard;
    bms_rdf_pkg::phase_e    phase;
    logic [15:0]            run_sum;
    logic [7:0]             byte_idx;
    logic [7:0]             decl_len;
    logic [7:0]             echo_q;
    logic [7:0]             status_q;
    logic [7:0]             chk_hi;
    logic [7:0]             chk_lo;
    bms_rdf_pkg::out_item_t pending[$];
    int                     mismatches;

    function new();
      phase      = bms_rdf_pkg::PH_HUNT;
      run_sum    = '0;
      byte_idx   = '0;
      decl_len   = '0;
      echo_q     = '0;
      status_q   = '0;
      chk_hi     = '0;
      chk_lo     = '0;
      mismatches = 0;
    endfunction

    function void note_input(bms_rdf_pkg::in_item_t it);
      bms_rdf_pkg::out_item_t r;
      logic                   have;
      logic [7:0]             b;
      logic [15:0]            want;
      r    = '0;
      have = 1'b0;
      b    = it.rx_byte;
      if (it.command == bms_rdf_pkg::CMD_GAP) begin
        if (phase != bms_rdf_pkg::PH_HUNT) begin
          r.kind    = bms_rdf_pkg::KIND_VERDICT;
          r.verdict = bms_rdf_pkg::V_TRUNCATED;
          have      = 1'b1;
          phase     = bms_rdf_pkg::PH_HUNT;
        end
      end else begin
        case (phase)
          bms_rdf_pkg::PH_HUNT: begin
            if (b == bms_rdf_pkg::START_BYTE) begin
              run_sum  = '0;
              byte_idx = '0;
              decl_len = '0;
              echo_q   = '0;
              status_q = '0;
              chk_hi   = '0;
              chk_lo   = '0;
              phase    = bms_rdf_pkg::PH_ECHO;
            end
          end
          bms_rdf_pkg::PH_ECHO: begin
            echo_q = b;
            phase  = bms_rdf_pkg::PH_STATUS;
          end
          bms_rdf_pkg::PH_STATUS: begin
            status_q = b;
            run_sum  = run_sum + b;
            phase    = bms_rdf_pkg::PH_LEN;
          end
          bms_rdf_pkg::PH_LEN: begin
            decl_len = b;
            run_sum  = run_sum + b;
            byte_idx = '0;
            if (bms_rdf_pkg::FrameOverhead + b > bms_rdf_pkg::MaxFrameBytes) begin
              r.kind    = bms_rdf_pkg::KIND_VERDICT;
              r.verdict = bms_rdf_pkg::V_TOO_LONG;
              have      = 1'b1;
              phase     = bms_rdf_pkg::PH_HUNT;
            end else if (b == 8'd0) begin
              phase = bms_rdf_pkg::PH_CHK_HI;
            end else begin
              phase = bms_rdf_pkg::PH_PAYLOAD;
            end
          end
          bms_rdf_pkg::PH_PAYLOAD: begin
            run_sum         = run_sum + b;
            r.kind          = bms_rdf_pkg::KIND_PAYLOAD;
            r.payload_byte  = b;
            r.payload_index = byte_idx[bms_rdf_pkg::IdxW-1:0];
            r.verdict       = bms_rdf_pkg::V_OK;
            have            = 1'b1;
            byte_idx        = byte_idx + 8'd1;
            if (byte_idx >= decl_len) phase = bms_rdf_pkg::PH_CHK_HI;
          end
          bms_rdf_pkg::PH_CHK_HI: begin
            chk_hi = b;
            phase  = bms_rdf_pkg::PH_CHK_LO;
          end
          bms_rdf_pkg::PH_CHK_LO: begin
            chk_lo = b;
            phase  = bms_rdf_pkg::PH_END;
          end
          default: begin
            want   = 16'h0000 - run_sum;
            r.kind = bms_rdf_pkg::KIND_VERDICT;
            if (b != bms_rdf_pkg::END_BYTE) r.verdict = bms_rdf_pkg::V_BAD_END;
            else if ({chk_hi, chk_lo} != want) r.verdict = bms_rdf_pkg::V_CHECKSUM;
            else r.verdict = bms_rdf_pkg::V_OK;
            have  = 1'b1;
            phase = bms_rdf_pkg::PH_HUNT;
          end
        endcase
      end
      if (have) begin
        r.echo_code      = echo_q;
        r.status_code    = status_q;
        r.payload_length = decl_len;
        pending.push_back(r);
      end
    endfunction

    function void check_result(bms_rdf_pkg::out_item_t got);
      bms_rdf_pkg::out_item_t want;
      if (pending.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: kind %0d byte %02h idx %0d verdict %0d",
                   got.kind, got.payload_byte, got.payload_index, got.verdict);
        mismatches++;
      end else begin
        want = pending.pop_front();
        if (got.kind != want.kind || got.payload_byte != want.payload_byte ||
            got.payload_index != want.payload_index || got.verdict != want.verdict ||
            got.echo_code != want.echo_code || got.status_code != want.status_code ||
            got.payload_length != want.payload_length) begin
          if (mismatches < 10) begin
            $display({"mismatch exp: kind %0d byte %02h idx %0d verdict %0d",
                      " echo %02h st %02h len %0d"},
                     want.kind, want.payload_byte, want.payload_index, want.verdict,
                     want.echo_code, want.status_code, want.payload_length);
            $display({"         got: kind %0d byte %02h idx %0d verdict %0d",
                      " echo %02h st %02h len %0d"},
                     got.kind, got.payload_byte, got.payload_index, got.verdict,
                     got.echo_code, got.status_code, got.payload_length);
          end
          mismatches++;
        end
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  bms_rdf_pkg::in_item_t  in_item = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  bms_rdf_pkg::out_item_t out_item;

  frame_scoreboard       sb;
  bms_rdf_pkg::in_item_t rx_stream[$];
  int unsigned           accepted = 0;
  bit                    quiet = 1'b0;
  bit                    hold_off_req = 1'b0;

  bms_response_deframer_core u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  always #5 clk = ~clk;

  // transfer monitor on both channels
  always @(posedge clk) begin
    if (rst_n && sb != null) begin
      if (in_valid && in_ready) begin
        sb.note_input(in_item);
        accepted++;
      end
      if (out_valid && out_ready) sb.check_result(out_item);
    end
  end

  function automatic void push_byte(logic [7:0] b);
    bms_rdf_pkg::in_item_t it;
    it.command = CMD_BYTE;
    it.rx_byte = b;
    rx_stream.push_back(it);
  endfunction

  function automatic void push_gap();
    bms_rdf_pkg::in_item_t it;
    it.command = bms_rdf_pkg::CMD_GAP;
    it.rx_byte = 8'($urandom);
    rx_stream.push_back(it);
  endfunction

  function automatic void build_frame(logic [7:0] echo, logic [7:0] status, int len,
                                      flaw_e flaw, bit dd_fill);
    logic [7:0]  fr[$];
    logic [7:0]  pb;
    logic [15:0] sum;
    logic [15:0] chk;
    logic [7:0]  end_b;
    int          cut;
    fr.push_back(bms_rdf_pkg::START_BYTE);
    fr.push_back(echo);
    fr.push_back(status);
    fr.push_back(8'(len));
    sum = 16'(status) + 16'(8'(len));
    if (flaw != FR_OVERSIZE) begin
      for (int i = 0; i < len; i++) begin
        pb = dd_fill ? bms_rdf_pkg::START_BYTE : 8'($urandom);
        if (!dd_fill && $urandom_range(0, 15) == 0) pb = bms_rdf_pkg::START_BYTE;
        fr.push_back(pb);
        sum = sum + pb;
      end
      chk = 16'h0000 - sum;
      if (flaw == FR_BAD_SUM) chk = chk ^ 16'($urandom_range(1, 16'hFFFF));
      fr.push_back(chk[15:8]);
      fr.push_back(chk[7:0]);
      end_b = bms_rdf_pkg::END_BYTE;
      if (flaw == FR_BAD_END) begin
        if (dd_fill) end_b = bms_rdf_pkg::START_BYTE;
        else end_b = bms_rdf_pkg::END_BYTE ^ 8'($urandom_range(1, 255));
      end
      fr.push_back(end_b);
    end
    if (flaw == FR_CUT) begin
      cut = $urandom_range(1, fr.size() - 1);
      for (int i = 0; i < cut; i++) push_byte(fr[i]);
      push_gap();
    end else begin
      foreach (fr[i]) push_byte(fr[i]);
    end
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return bms_rdf_pkg::MaxFrameBytes - bms_rdf_pkg::FrameOverhead;
    if (r < 3)
      return $urandom_range(9, bms_rdf_pkg::MaxFrameBytes - bms_rdf_pkg::FrameOverhead);
    return $urandom_range(0, 8);
  endfunction

  function automatic void random_frame();
    int                    r;
    int                    n;
    int                    len;
    flaw_e                 flaw;
    bms_rdf_pkg::in_item_t it;
    r = $urandom_range(0, 99);
    if (r >= 96) begin
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
        it.command = 1'($urandom);
        it.rx_byte = 8'($urandom);
        rx_stream.push_back(it);
      end
      return;
    end
    if (r < 70) flaw = FR_GOOD;
    else if (r < 78) flaw = FR_BAD_END;
    else if (r < 86) flaw = FR_BAD_SUM;
    else if (r < 93) flaw = FR_CUT;
    else flaw = FR_OVERSIZE;
    if (flaw == FR_OVERSIZE) begin
      if ($urandom_range(0, 3) == 0)
        len = bms_rdf_pkg::MaxFrameBytes - bms_rdf_pkg::FrameOverhead + 1;
      else
        len = $urandom_range(bms_rdf_pkg::MaxFrameBytes - bms_rdf_pkg::FrameOverhead + 1,
                             255);
    end else begin
      len = pick_len();
    end
    build_frame(8'($urandom), 8'($urandom), len, flaw, 1'b0);
    if ($urandom_range(0, 1) == 0) push_gap();
  endfunction

  task automatic send(bms_rdf_pkg::in_item_t it);
    int g;
    g = quiet ? 0 : $urandom_range(0, 9);
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_stream();
    while (rx_stream.size() != 0) send(rx_stream.pop_front());
  endtask

  task automatic bus_idle();
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // result side
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        stall = quiet ? 0 : $urandom_range(0, 9);
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    bit held_once;
    held_once = 1'b0;
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed frames and corner cases
    push_gap();
    push_byte(8'h00);
    build_frame(8'hFF, 8'h00, 0, FR_GOOD, 1'b0);
    build_frame(8'h00, 8'hFF, 1, FR_BAD_END, 1'b1);
    build_frame(8'hA5, 8'h5A, 255, FR_OVERSIZE, 1'b0);
    build_frame(8'h01, 8'h80, bms_rdf_pkg::MaxFrameBytes - bms_rdf_pkg::FrameOverhead + 1,
                FR_OVERSIZE, 1'b0);
    push_byte(bms_rdf_pkg::START_BYTE);
    push_gap();
    drain_stream();

    while (accepted < ItemTarget) begin
      if (!held_once && accepted >= 900) begin
        // back pressure: output held off while long frames keep coming
        bus_idle();
        wait_drained();
        hold_off_req = 1'b1;
        quiet = 1'b1;
        for (int i = 0; i < 4; i++)
          build_frame(8'($urandom), 8'($urandom), $urandom_range(20, 57), FR_GOOD, 1'b0);
        drain_stream();
        bus_idle();
        while (hold_off_req) @(posedge clk);
        quiet = 1'b0;
        wait_drained();
        held_once = 1'b1;
      end
      quiet = (accepted >= 500 && accepted < 800);
      random_frame();
      drain_stream();
    end

    bus_idle();
    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("bms_response_deframer_core_test OK");
    end else begin
      $display("bms_response_deframer_core_test NOT OK");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("bms_response_deframer_core_test NOT OK");
    $finish;
  end

endmodule
